/* design/rln_pkg.sv */
// ----------------------------------------------------------------------------
// rln_pkg: shared types and constants for the relative difference norm block
// Holds output field widths, controller state type and command/status bundles.
// ----------------------------------------------------------------------------
package rln_pkg;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;
    localparam int L2RefW   = 26;
    localparam int L2DiffW  = 27;
    localparam int L1RefW   = 36;
    localparam int L1DiffW  = 37;
    localparam int RelW     = 32;
    localparam int SqrtStepW = 6;
    localparam int DivStepW  = 7;

    localparam logic [CfgIdxW-1:0] REG_ROW_FIRST = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_ROW_LIMIT = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_COL_FIRST = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_COL_LIMIT = 2'd3;

    typedef enum logic [4:0] {
        ST_ACC   = 5'b00001,
        ST_SQRT  = 5'b00010,
        ST_DIV2  = 5'b00100,
        ST_DIV1  = 5'b01000,
        ST_OUT   = 5'b10000
    } rln_state_t;

    typedef struct packed {
        logic accumulate;
        logic sqrt_start;
        logic sqrt_step;
        logic div_start_l2;
        logic div_start_l1;
        logic div_step;
        logic capture;
        logic clear;
    } rln_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
    } rln_status_t;

endpackage

/* design/rln_if.sv */
// ----------------------------------------------------------------------------
// rln_if: valid/ready channel carrying one payload beat
// Generic stream interface with source and sink modports.
// ----------------------------------------------------------------------------
interface rln_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/relative_l2_l1_difference_norms.sv */
// ----------------------------------------------------------------------------
// relative_l2_l1_difference_norms: relative L2/L1 error norms of two grids
// Windowed saturating accumulation with square root and Q16.16 ratio output.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one beat per sample pair (ref, test, row, column, last).
//   Pairs inside the row/column window add into six saturating sums, one beat
//   per cycle. A beat with last_pair set closes the set: after it the input
//   stalls while the digit-serial square root runs (all three roots at once,
//   32 digits each), then while the two bit-serial divisions run on one
//   shared divider (80 quotient bits each), and then while the result beat is
//   loaded into the output register and the sums are cleared.
//   out_ch holds its beat until taken. If the previous result still waits
//   when the next set is ready to load, hold the load and keep the input
//   stalled until that beat leaves.
//   Configuration writes (cfg_we, cfg_index, cfg_data) set the window bounds;
//   the user must make them only while the block is idle (not enforced here).
//   Reset clears the sums, the flag and the window to rows/columns 0..65534.
module relative_l2_l1_difference_norms #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_LOG2  = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [rln_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [rln_pkg::CfgDataW-1:0] cfg_data,
    rln_if.sink                          in_ch,
    rln_if.source                        out_ch
);
    import rln_pkg::*;

    rln_cmd_t    cmd;
    rln_status_t status;

    rln_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.data.last_pair),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rln_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_LOG2  (COUNT_LOG2)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .ref_sample     (in_ch.data.ref_sample[SAMPLE_BITS-1:0]),
        .test_sample    (in_ch.data.test_sample[SAMPLE_BITS-1:0]),
        .row_index      (in_ch.data.row_index),
        .col_index      (in_ch.data.col_index),
        .l2_ref         (out_ch.data.l2_ref),
        .l2_test        (out_ch.data.l2_test),
        .l2_diff        (out_ch.data.l2_diff),
        .l1_ref         (out_ch.data.l1_ref),
        .l1_test        (out_ch.data.l1_test),
        .l1_diff        (out_ch.data.l1_diff),
        .rel_l2         (out_ch.data.rel_l2),
        .rel_l1         (out_ch.data.rel_l1),
        .zero_reference (out_ch.data.zero_reference),
        .sum_saturated  (out_ch.data.sum_saturated)
    );
endmodule

/* design/rln_ctrl.sv */
// ----------------------------------------------------------------------------
// rln_ctrl: controller for the relative difference norm block
// Sequences accumulation, square roots, the two divisions and output.
// ----------------------------------------------------------------------------
module rln_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_last,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  rln_pkg::rln_status_t  status,
    output rln_pkg::rln_cmd_t     cmd
);
    import rln_pkg::*;

    rln_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_ACC:
            begin
                in_ready       = 1'b1;
                cmd.accumulate = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_done)
                begin
                    state_next       = ST_DIV2;
                    cmd.div_start_l2 = 1'b1;
                end
            end
            ST_DIV2:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next       = ST_DIV1;
                    cmd.div_start_l1 = 1'b1;
                end
            end
            ST_DIV1:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // wait for the previous result beat to leave the output register
                if (!out_valid_reg || out_ready)
                begin
                    cmd.capture    = 1'b1;
                    cmd.clear      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
        cmd.sqrt_start = cmd.accumulate && in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("controller state not one-hot");
    a_capture_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");
    a_ready_acc: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_ACC)
        else $error("input taken outside accumulation");
endmodule

/* design/rln_dp.sv */
// ----------------------------------------------------------------------------
// rln_dp: datapath for the relative difference norm block
// Saturating accumulators, three parallel digit-serial square roots, shared divider.
// ----------------------------------------------------------------------------
module rln_dp #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_LOG2  = 20
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rln_pkg::rln_cmd_t           cmd,
    output rln_pkg::rln_status_t        status,
    input  logic                        cfg_we,
    input  logic [rln_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [rln_pkg::CfgDataW-1:0] cfg_data,
    input  logic [SAMPLE_BITS-1:0]      ref_sample,
    input  logic [SAMPLE_BITS-1:0]      test_sample,
    input  logic [15:0]                 row_index,
    input  logic [15:0]                 col_index,
    output logic [rln_pkg::L2RefW-1:0]  l2_ref,
    output logic [rln_pkg::L2RefW-1:0]  l2_test,
    output logic [rln_pkg::L2DiffW-1:0] l2_diff,
    output logic [rln_pkg::L1RefW-1:0]  l1_ref,
    output logic [rln_pkg::L1RefW-1:0]  l1_test,
    output logic [rln_pkg::L1DiffW-1:0] l1_diff,
    output logic [rln_pkg::RelW-1:0]    rel_l2,
    output logic [rln_pkg::RelW-1:0]    rel_l1,
    output logic                        zero_reference,
    output logic                        sum_saturated
);
    import rln_pkg::*;

    localparam int SqW   = (2*SAMPLE_BITS+COUNT_LOG2 > 63) ? 63 : 2*SAMPLE_BITS+COUNT_LOG2;
    localparam int SqdW  = (2*SAMPLE_BITS+COUNT_LOG2+2 > 63) ? 63 : 2*SAMPLE_BITS+COUNT_LOG2+2;
    localparam int AbW   = (SAMPLE_BITS+COUNT_LOG2 > 63) ? 63 : SAMPLE_BITS+COUNT_LOG2;
    localparam int AbdW  = (SAMPLE_BITS+COUNT_LOG2+1 > 63) ? 63 : SAMPLE_BITS+COUNT_LOG2+1;
    localparam int MagW  = SAMPLE_BITS + 1;
    localparam int SqRun = 32;                  // digits of each square root
    localparam int RootW = 32;
    localparam int RadW  = 64;
    localparam int DivW  = 64;                  // dividend/divisor width
    localparam int DivSteps = 80;               // 64 integer + 16 fraction bits

    // configuration
    logic [15:0] row_first_reg, row_limit_reg, col_first_reg, col_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_first_reg <= 16'd0;
            row_limit_reg <= 16'hFFFF;
            col_first_reg <= 16'd0;
            col_limit_reg <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_FIRST: row_first_reg <= cfg_data;
                REG_ROW_LIMIT: row_limit_reg <= cfg_data;
                REG_COL_FIRST: col_first_reg <= cfg_data;
                REG_COL_LIMIT: col_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // magnitudes and squares
    logic signed [MagW-1:0] r_s, t_s, d_s;
    logic [MagW-1:0]        ar, at, ad;
    logic [2*MagW-1:0]      ar2, at2, ad2;
    logic                   in_win;

    assign r_s = MagW'($signed(ref_sample));
    assign t_s = MagW'($signed(test_sample));
    assign d_s = r_s - t_s;
    assign ar  = r_s[MagW-1] ? MagW'(-r_s) : MagW'(r_s);
    assign at  = t_s[MagW-1] ? MagW'(-t_s) : MagW'(t_s);
    assign ad  = d_s[MagW-1] ? MagW'(-d_s) : MagW'(d_s);
    assign ar2 = ar * ar;
    assign at2 = at * at;
    assign ad2 = ad * ad;
    assign in_win = (row_index >= row_first_reg) && (row_index < row_limit_reg)
                 && (col_index >= col_first_reg) && (col_index < col_limit_reg);

    logic [SqW-1:0]  sq_ref_reg, sq_test_reg;
    logic [SqdW-1:0] sq_diff_reg;
    logic [AbW-1:0]  ab_ref_reg, ab_test_reg;
    logic [AbdW-1:0] ab_diff_reg;
    logic            sat_reg;

    logic [SqW:0]  s_sr, s_st;
    logic [SqdW:0] s_sd;
    logic [AbW:0]  s_ar, s_at;
    logic [AbdW:0] s_ad;

    assign s_sr = {1'b0, sq_ref_reg}  + (SqW+1)'(ar2);
    assign s_st = {1'b0, sq_test_reg} + (SqW+1)'(at2);
    assign s_sd = {1'b0, sq_diff_reg} + (SqdW+1)'(ad2);
    assign s_ar = {1'b0, ab_ref_reg}  + (AbW+1)'(ar);
    assign s_at = {1'b0, ab_test_reg} + (AbW+1)'(at);
    assign s_ad = {1'b0, ab_diff_reg} + (AbdW+1)'(ad);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_ref_reg  <= '0;
            sq_test_reg <= '0;
            sq_diff_reg <= '0;
            ab_ref_reg  <= '0;
            ab_test_reg <= '0;
            ab_diff_reg <= '0;
            sat_reg     <= 1'b0;
        end
        else if (cmd.clear)
        begin
            sq_ref_reg  <= '0;
            sq_test_reg <= '0;
            sq_diff_reg <= '0;
            ab_ref_reg  <= '0;
            ab_test_reg <= '0;
            ab_diff_reg <= '0;
            sat_reg     <= 1'b0;
        end
        else if (cmd.accumulate && in_win)
        begin
            sq_ref_reg  <= s_sr[SqW]  ? '1 : s_sr[SqW-1:0];
            sq_test_reg <= s_st[SqW]  ? '1 : s_st[SqW-1:0];
            sq_diff_reg <= s_sd[SqdW] ? '1 : s_sd[SqdW-1:0];
            ab_ref_reg  <= s_ar[AbW]  ? '1 : s_ar[AbW-1:0];
            ab_test_reg <= s_at[AbW]  ? '1 : s_at[AbW-1:0];
            ab_diff_reg <= s_ad[AbdW] ? '1 : s_ad[AbdW-1:0];
            sat_reg     <= sat_reg | s_sr[SqW] | s_st[SqW] | s_sd[SqdW]
                         | s_ar[AbW] | s_at[AbW] | s_ad[AbdW];
        end
    end

    // three square roots run side by side, one digit per cycle; sums are
    // taken after the final accumulate, so start in the cycle after sqrt_start
    logic                 sq_go_reg;
    logic [SqrtStepW-1:0] sq_cnt_reg;
    logic [RadW-1:0]      rad_reg [3];
    logic [RootW-1:0]     root_reg [3];
    logic [RootW+1:0]     remd_reg [3];
    logic [RootW+1:0]     trial [3];
    logic [RootW+1:0]     rnext [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rnext[k] = {remd_reg[k][RootW-1:0], rad_reg[k][RadW-1:RadW-2]};
            trial[k] = rnext[k] - {root_reg[k], 2'b01};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_go_reg  <= 1'b0;
            sq_cnt_reg <= '0;
        end
        else
        begin
            sq_go_reg <= cmd.sqrt_start;
            if (sq_go_reg)
            begin
                sq_cnt_reg <= SqrtStepW'(SqRun);
            end
            else if (cmd.sqrt_step && sq_cnt_reg != '0)
            begin
                sq_cnt_reg <= sq_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_go_reg)
        begin
            rad_reg[0]  <= RadW'(sq_ref_reg);
            rad_reg[1]  <= RadW'(sq_test_reg);
            rad_reg[2]  <= RadW'(sq_diff_reg);
            for (int k = 0; k < 3; k++)
            begin
                root_reg[k] <= '0;
                remd_reg[k] <= '0;
            end
        end
        else if (cmd.sqrt_step && sq_cnt_reg != '0)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rad_reg[k] <= {rad_reg[k][RadW-3:0], 2'b00};
                if (!trial[k][RootW+1])
                begin
                    remd_reg[k] <= trial[k];
                    root_reg[k] <= {root_reg[k][RootW-2:0], 1'b1};
                end
                else
                begin
                    remd_reg[k] <= rnext[k];
                    root_reg[k] <= {root_reg[k][RootW-2:0], 1'b0};
                end
            end
        end
    end

    assign status.sqrt_done = cmd.sqrt_step && !sq_go_reg && (sq_cnt_reg == '0);

    // shared restoring divider: quotient of a*65536 / b, one bit per cycle
    logic [DivStepW-1:0] dv_cnt_reg;
    logic [DivW-1:0]     dv_num_reg;   // dividend bits still to shift in
    logic [DivW-1:0]     dv_den_reg;
    logic [DivW:0]       dv_rem_reg;
    logic [DivSteps-1:0] dv_q_reg;
    logic [DivW:0]       dv_sh, dv_sub;
    logic [DivW-1:0]     num_sel, den_sel;

    assign dv_sh  = {dv_rem_reg[DivW-1:0], dv_num_reg[DivW-1]};
    assign dv_sub = dv_sh - {1'b0, dv_den_reg};
    assign num_sel = cmd.div_start_l2 ? DivW'(root_reg[2]) : DivW'(ab_diff_reg);
    assign den_sel = cmd.div_start_l2 ? DivW'(root_reg[0]) : DivW'(ab_ref_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_cnt_reg <= '0;
        end
        else if (cmd.div_start_l2 || cmd.div_start_l1)
        begin
            dv_cnt_reg <= DivStepW'(DivSteps);
        end
        else if (cmd.div_step && dv_cnt_reg != '0)
        begin
            dv_cnt_reg <= dv_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start_l2 || cmd.div_start_l1)
        begin
            dv_num_reg <= num_sel;
            dv_den_reg <= den_sel;
            dv_rem_reg <= '0;
            dv_q_reg   <= '0;
        end
        else if (cmd.div_step && dv_cnt_reg != '0)
        begin
            dv_num_reg <= {dv_num_reg[DivW-2:0], 1'b0};
            if (!dv_sub[DivW])
            begin
                dv_rem_reg <= dv_sub;
                dv_q_reg   <= {dv_q_reg[DivSteps-2:0], 1'b1};
            end
            else
            begin
                dv_rem_reg <= dv_sh;
                dv_q_reg   <= {dv_q_reg[DivSteps-2:0], 1'b0};
            end
        end
    end

    assign status.div_done = cmd.div_step && (dv_cnt_reg == '0);

    logic [RelW-1:0] q_sat, rel_l2_hold_reg;
    assign q_sat = (dv_q_reg[DivSteps-1:RelW] != '0) ? '1 : dv_q_reg[RelW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.div_start_l1)
        begin
            rel_l2_hold_reg <= q_sat;
        end
    end

    // output register
    logic zero_w;
    assign zero_w = (root_reg[0] == '0) || (ab_ref_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            l2_ref  <= (root_reg[0] > RootW'({L2RefW{1'b1}})) ? '1 : L2RefW'(root_reg[0]);
            l2_test <= (root_reg[1] > RootW'({L2RefW{1'b1}})) ? '1 : L2RefW'(root_reg[1]);
            l2_diff <= (root_reg[2] > RootW'({L2DiffW{1'b1}})) ? '1 : L2DiffW'(root_reg[2]);
            l1_ref  <= (AbW > L1RefW && (ab_ref_reg >> L1RefW) != '0) ? '1 : L1RefW'(ab_ref_reg);
            l1_test <= (AbW > L1RefW && (ab_test_reg >> L1RefW) != '0) ? '1 : L1RefW'(ab_test_reg);
            l1_diff <= (AbdW > L1DiffW && (ab_diff_reg >> L1DiffW) != '0) ? '1
                       : L1DiffW'(ab_diff_reg);
            rel_l2  <= zero_w ? '1 : rel_l2_hold_reg;
            rel_l1  <= zero_w ? '1 : q_sat;
            zero_reference <= zero_w;
            sum_saturated  <= sat_reg;
        end
    end

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accumulate |-> dv_cnt_reg == '0)
        else $error("divider busy while accumulating");
    a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> sq_cnt_reg == '0)
        else $error("divide overlaps square root");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (sq_ref_reg == '0 && ab_ref_reg == '0 && !sat_reg))
        else $error("sums not cleared");
endmodule
